// ===== rtl/vna_pkg.sv =====
// Shared widths, item codes and defaults of the vertex normal accumulator.
package vna_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int SUM_BITS_DEF     = 24;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 24;
    localparam int NRM_W  = 16;
    localparam int EDGE_W = POS_W + 1;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 64;
    localparam int CR_W   = 52;
    localparam int MAG_W  = 51;
    localparam int SQ_W   = 64;
    localparam int LEN_W  = 32;
    localparam int NUM_W  = 50;
    localparam int Q_W    = 17;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_TRI  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

endpackage

// ===== rtl/vna_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vna_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/vna_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module vna_sqrt import vna_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SQ_W-1:0]  radicand,
    output logic [LEN_W-1:0] root,
    output logic             done
);

    logic [SQ_W-1:0] x_reg;
    logic [SQ_W-1:0] r_reg;
    logic [SQ_W-1:0] bit_reg;
    logic [4:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [SQ_W-1:0] trial;

    assign trial = r_reg + bit_reg;
    assign root  = r_reg[LEN_W-1:0];
    assign done  = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= radicand;
                r_reg    <= '0;
                bit_reg  <= SQ_W'(1) << (SQ_W - 2);
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (x_reg >= trial) begin
                    x_reg <= x_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/vna_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module vna_div import vna_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [LEN_W-1:0] denom,
    output logic [Q_W-1:0]   quot,
    output logic             done
);

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    assign quot = q_reg;
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= numer;
                den_reg  <= NUM_W'(denom) << (Q_W - 1);
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (rem_reg >= den_reg) begin
                    rem_reg <= rem_reg - den_reg;
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                end
                den_reg <= den_reg >> 1;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/vertex_normal_accumulator.sv =====
// Top level of the vertex normal accumulator: sequencer, shared multiplier and stores.
//
// Input channel s_*: one beat is a load, a triangle or a read (s_kind).
// Result channel m_*: one beat for each read, carrying a Q1.14 unit normal
// and m_is_zero when the vertex sum had zero length or the index is out of range.
// After reset the normal sum store is cleared one entry per cycle, and s_ready
// stays low until every entry is cleared. Positions are not cleared.
// A load is taken without leaving idle, and a kind-3 beat is dropped.
// A read (skipping the root and divisions for a zero-length sum or an index out
// of range) and a triangle (ending after the cross product when degenerate,
// dropped with a corner out of range) use the 32-step square root, three
// 17-step divisions, up to 19 one-bit normalizing shifts and the single
// 33x33 multiplier shared by the cross product and the sum of squares.
// s_ready is high only while the sequencer is idle.
// A finished result sits in the output register; the block takes new beats
// while it waits, and a later read holds until the receiver has taken it.
module vertex_normal_accumulator import vna_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int SUM_BITS     = SUM_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_kind,
    input  logic [IDX_W-1:0]        s_vertex_index,
    input  logic signed [POS_W-1:0] s_pos_x,
    input  logic signed [POS_W-1:0] s_pos_y,
    input  logic signed [POS_W-1:0] s_pos_z,
    input  logic [IDX_W-1:0]        s_corner_a,
    input  logic [IDX_W-1:0]        s_corner_b,
    input  logic [IDX_W-1:0]        s_corner_c,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [NRM_W-1:0] m_normal_x,
    output logic signed [NRM_W-1:0] m_normal_y,
    output logic signed [NRM_W-1:0] m_normal_z,
    output logic                    m_is_zero
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int SW = 3 * SUM_BITS;
    localparam logic signed [SUM_BITS:0] SMAX =
        (SUM_BITS+1)'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS:0] SMIN = -SMAX - (SUM_BITS+1)'(1);

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_RD_SUM, ST_LD_SUM, ST_PA, ST_PB, ST_PC, ST_PCAP,
        ST_MUL, ST_ACC, ST_MAG, ST_NORM, ST_SQM, ST_SQA, ST_SQS, ST_SQW,
        ST_DIVS, ST_DIVW, ST_RMW_RD, ST_RMW_WR, ST_PUB
    } state_t;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] v);
        return 32'(v) < MAX_VERTICES;
    endfunction

    state_t state_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] vi_reg;
    logic [IDX_W-1:0] corner_reg [3];
    logic is_tri_reg;
    logic [2:0] k_reg;
    logic [1:0] idx_reg;
    logic signed [POS_W-1:0] pa_reg [3];
    logic signed [POS_W-1:0] pb_reg [3];
    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [CR_W-1:0] cr_reg [3];
    logic [MAG_W-1:0] m_reg [3];
    logic neg_reg [3];
    logic [SQ_W-1:0] sq_reg;
    logic [LEN_W-1:0] len_reg;
    logic signed [Q_W-1:0] n_reg [3];
    logic zero_reg;
    logic m_valid_reg;
    logic signed [NRM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic m_zero_reg;

    logic s_accept;
    logic pos_we;
    logic [AW-1:0] pos_raddr;
    logic [3*POS_W-1:0] pos_rdata;
    logic sum_we;
    logic [AW-1:0] sum_waddr, sum_raddr;
    logic [SW-1:0] sum_wdata, sum_rdata;
    logic signed [POS_W-1:0] pos_rd [3];
    logic signed [CR_W-1:0] abs_src [3];
    logic signed [CR_W-1:0] abs_val [3];
    logic signed [SUM_BITS:0] sat_sum [3];
    logic [SW-1:0] rmw_data;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod_full;
    logic sqrt_start, sqrt_done, div_start, div_done;
    logic [LEN_W-1:0] sqrt_root;
    logic [NUM_W-1:0] div_num;
    logic [Q_W-1:0] div_q;
    logic [31:0] m_low;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_normal_x = nx_reg;
    assign m_normal_y = ny_reg;
    assign m_normal_z = nz_reg;
    assign m_is_zero  = m_zero_reg;

    assign pos_we = s_accept && (s_kind == KIND_LOAD) && in_range(s_vertex_index);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_rd[i]  = signed'(pos_rdata[i*POS_W +: POS_W]);
            abs_src[i] = (state_reg == ST_LD_SUM) ?
                CR_W'(signed'(sum_rdata[i*SUM_BITS +: SUM_BITS])) : cr_reg[i];
            abs_val[i] = abs_src[i][CR_W-1] ? -abs_src[i] : abs_src[i];
            sat_sum[i] = (SUM_BITS+1)'(signed'(sum_rdata[i*SUM_BITS +: SUM_BITS]))
                       + (SUM_BITS+1)'(n_reg[i]);
            if (sat_sum[i] > SMAX) begin
                rmw_data[i*SUM_BITS +: SUM_BITS] = SMAX[SUM_BITS-1:0];
            end else if (sat_sum[i] < SMIN) begin
                rmw_data[i*SUM_BITS +: SUM_BITS] = SMIN[SUM_BITS-1:0];
            end else begin
                rmw_data[i*SUM_BITS +: SUM_BITS] = sat_sum[i][SUM_BITS-1:0];
            end
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_PA:   pos_raddr = to_addr(corner_reg[0]);
            ST_PB:   pos_raddr = to_addr(corner_reg[1]);
            default: pos_raddr = to_addr(corner_reg[2]);
        endcase
    end

    always_comb begin
        sum_we    = 1'b0;
        sum_waddr = to_addr(s_vertex_index);
        sum_wdata = '0;
        priority if (state_reg == ST_CLR) begin
            sum_we    = 1'b1;
            sum_waddr = clr_cnt_reg;
        end else if (state_reg == ST_RMW_WR) begin
            sum_we    = 1'b1;
            sum_waddr = to_addr(corner_reg[idx_reg]);
            sum_wdata = rmw_data;
        end else if (pos_we) begin
            sum_we    = 1'b1;
        end
        sum_raddr = (state_reg == ST_RD_SUM) ? to_addr(vi_reg) : to_addr(corner_reg[idx_reg]);
    end

    always_comb begin
        mul_a = signed'({1'b0, m_reg[idx_reg][31:0]});
        mul_b = mul_a;
        if (state_reg == ST_MUL) begin
            unique case (k_reg)
                3'd0: begin mul_a = MUL_W'(e1_reg[1]); mul_b = MUL_W'(e2_reg[2]); end
                3'd1: begin mul_a = MUL_W'(e1_reg[2]); mul_b = MUL_W'(e2_reg[1]); end
                3'd2: begin mul_a = MUL_W'(e1_reg[2]); mul_b = MUL_W'(e2_reg[0]); end
                3'd3: begin mul_a = MUL_W'(e1_reg[0]); mul_b = MUL_W'(e2_reg[2]); end
                3'd4: begin mul_a = MUL_W'(e1_reg[0]); mul_b = MUL_W'(e2_reg[1]); end
                default: begin mul_a = MUL_W'(e1_reg[1]); mul_b = MUL_W'(e2_reg[0]); end
            endcase
        end
    end

    assign prod_full  = mul_a * mul_b;
    assign sqrt_start = (state_reg == ST_SQS) && (sq_reg != '0);
    assign div_start  = (state_reg == ST_DIVS);
    assign m_low      = m_reg[idx_reg][31:0];
    assign div_num    = (is_tri_reg ? (NUM_W'(m_low) << 15) : (NUM_W'(m_low) << 14))
                      + NUM_W'(len_reg >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
            idx_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_PUB)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(MAX_VERTICES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    vi_reg        <= s_vertex_index;
                    corner_reg[0] <= s_corner_a;
                    corner_reg[1] <= s_corner_b;
                    corner_reg[2] <= s_corner_c;
                    if (s_accept) begin
                        unique case (s_kind)
                            KIND_TRI: begin
                                is_tri_reg <= 1'b1;
                                if (in_range(s_corner_a) && in_range(s_corner_b) &&
                                    in_range(s_corner_c)) begin
                                    state_reg <= ST_PA;
                                end
                            end
                            KIND_READ: begin
                                is_tri_reg <= 1'b0;
                                if (in_range(s_vertex_index)) begin
                                    state_reg <= ST_RD_SUM;
                                end else begin
                                    for (int i = 0; i < 3; i++) n_reg[i] <= '0;
                                    zero_reg  <= 1'b1;
                                    state_reg <= ST_PUB;
                                end
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RD_SUM: state_reg <= ST_LD_SUM;
                ST_LD_SUM: begin
                    for (int i = 0; i < 3; i++) begin
                        m_reg[i]   <= abs_val[i][MAG_W-1:0];
                        neg_reg[i] <= abs_src[i][CR_W-1];
                    end
                    idx_reg   <= '0;
                    sq_reg    <= '0;
                    state_reg <= ST_SQM;
                end
                ST_PA: state_reg <= ST_PB;
                ST_PB: begin
                    pa_reg    <= pos_rd;
                    state_reg <= ST_PC;
                end
                ST_PC: begin
                    pb_reg    <= pos_rd;
                    state_reg <= ST_PCAP;
                end
                ST_PCAP: begin
                    for (int i = 0; i < 3; i++) begin
                        e1_reg[i] <= EDGE_W'(pb_reg[i]) - EDGE_W'(pa_reg[i]);
                        e2_reg[i] <= EDGE_W'(pos_rd[i]) - EDGE_W'(pa_reg[i]);
                    end
                    k_reg     <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= prod_full[PROD_W-1:0];
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (!k_reg[0]) begin
                        cr_reg[k_reg[2:1]] <= prod_reg[CR_W-1:0];
                    end else begin
                        cr_reg[k_reg[2:1]] <= cr_reg[k_reg[2:1]] - prod_reg[CR_W-1:0];
                    end
                    k_reg     <= k_reg + 3'd1;
                    state_reg <= (k_reg == 3'd5) ? ST_MAG : ST_MUL;
                end
                ST_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        m_reg[i]   <= abs_val[i][MAG_W-1:0];
                        neg_reg[i] <= abs_src[i][CR_W-1];
                    end
                    if (cr_reg[0] == '0 && cr_reg[1] == '0 && cr_reg[2] == '0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if ((|m_reg[0][MAG_W-1:30]) || (|m_reg[1][MAG_W-1:30]) ||
                        (|m_reg[2][MAG_W-1:30])) begin
                        for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                    end else begin
                        idx_reg   <= '0;
                        sq_reg    <= '0;
                        state_reg <= ST_SQM;
                    end
                end
                ST_SQM: begin
                    prod_reg  <= prod_full[PROD_W-1:0];
                    state_reg <= ST_SQA;
                end
                ST_SQA: begin
                    sq_reg <= sq_reg + unsigned'(prod_reg);
                    if (idx_reg == 2'd2) begin
                        state_reg <= ST_SQS;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_SQM;
                    end
                end
                ST_SQS: begin
                    if (sq_reg == '0) begin
                        for (int i = 0; i < 3; i++) n_reg[i] <= '0;
                        zero_reg  <= 1'b1;
                        state_reg <= is_tri_reg ? ST_IDLE : ST_PUB;
                    end else begin
                        state_reg <= ST_SQW;
                    end
                end
                ST_SQW: begin
                    if (sqrt_done) begin
                        len_reg   <= sqrt_root;
                        idx_reg   <= '0;
                        state_reg <= ST_DIVS;
                    end
                end
                ST_DIVS: state_reg <= ST_DIVW;
                ST_DIVW: begin
                    if (div_done) begin
                        n_reg[idx_reg] <= neg_reg[idx_reg] ? -signed'(div_q) : signed'(div_q);
                        if (idx_reg == 2'd2) begin
                            zero_reg  <= 1'b0;
                            idx_reg   <= '0;
                            state_reg <= is_tri_reg ? ST_RMW_RD : ST_PUB;
                        end else begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= ST_DIVS;
                        end
                    end
                end
                ST_RMW_RD: state_reg <= ST_RMW_WR;
                ST_RMW_WR: begin
                    if (idx_reg == 2'd2) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= ST_RMW_RD;
                    end
                end
                ST_PUB: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        nx_reg      <= n_reg[0][NRM_W-1:0];
                        ny_reg      <= n_reg[1][NRM_W-1:0];
                        nz_reg      <= n_reg[2][NRM_W-1:0];
                        m_zero_reg  <= zero_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    vna_ram #(.WIDTH(3 * POS_W), .DEPTH(MAX_VERTICES), .AW(AW)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (to_addr(s_vertex_index)),
        .wdata ({s_pos_z, s_pos_y, s_pos_x}),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES), .AW(AW)) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    vna_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    vna_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (len_reg),
        .quot    (div_q),
        .done    (div_done)
    );

endmodule

// ===== rtl/vna_checker.sv =====
// Port-level assertions for the vertex normal accumulator and their bind.
module vna_checker import vna_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [1:0]              s_kind,
    input logic [IDX_W-1:0]        s_vertex_index,
    input logic signed [POS_W-1:0] s_pos_x,
    input logic signed [POS_W-1:0] s_pos_y,
    input logic signed [POS_W-1:0] s_pos_z,
    input logic [IDX_W-1:0]        s_corner_a,
    input logic [IDX_W-1:0]        s_corner_b,
    input logic [IDX_W-1:0]        s_corner_c,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [NRM_W-1:0] m_normal_x,
    input logic signed [NRM_W-1:0] m_normal_y,
    input logic signed [NRM_W-1:0] m_normal_z,
    input logic                    m_is_zero
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_normal_x) &&
        $stable(m_normal_y) && $stable(m_normal_z) && $stable(m_is_zero))
        else $error("result beat changed while stalled");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_zero |-> m_normal_x == 0 && m_normal_y == 0 && m_normal_z == 0)
        else $error("zero flag with nonzero normal");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_x <= 16384 && m_normal_x >= -16384 &&
        m_normal_y <= 16384 && m_normal_y >= -16384 &&
        m_normal_z <= 16384 && m_normal_z >= -16384)
        else $error("normal component out of range");

    a_clear: assert property (@(posedge aclk) $rose(aresetn) |-> !s_ready)
        else $error("input taken during clearing pass");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);
